@@ rtl/frsc_pkg.sv @@
package frsc_pkg;

    // Operation codes carried in the operation field of an input item.
    localparam logic [1:0] OP_EDGE    = 2'd0;
    localparam logic [1:0] OP_REFRESH = 2'd1;
    localparam logic [1:0] OP_BEGIN   = 2'd2;
    localparam logic [1:0] OP_END     = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MOMENTARY_MODE  = 2'd0;
    localparam logic [1:0] CFG_EXT_PATCH_LIMIT = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE_MS     = 2'd2;
    localparam logic [1:0] CFG_EDGE_HOLDOFF_US = 2'd3;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Configuration reset values.
    localparam logic       RST_MOMENTARY_MODE     = 1'b0;
    localparam logic [5:0] RST_EXT_PATCH_LIMIT    = 6'd24;
    localparam logic [7:0] RST_DEBOUNCE_MS        = 8'd20;
    localparam logic [15:0] RST_EDGE_HOLDOFF_US   = 16'd5000;

    // Layout of the output word.
    localparam int PATTERN_BITS = 8;
    localparam int BIT_RELAY    = 0;
    localparam int BIT_T0       = 1;
    localparam int BIT_S0       = 2;
    localparam int BIT_EN0      = 5;
    localparam int BANK_COUNT   = 3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_us;
        logic [31:0] now_ms;
        logic        pin_level;
        logic [4:0]  program_req;
        logic [1:0]  bank_index;
    } frsc_in_t;

    typedef struct packed {
        logic [PATTERN_BITS-1:0] pattern;
        logic                    latched;
        logic                    accepted;
        logic                    eeprom_mode;
    } frsc_out_t;

    typedef struct packed {
        logic        momentary_mode;
        logic [5:0]  ext_patch_limit;
        logic [7:0]  debounce_ms;
        logic [15:0] edge_holdoff_us;
    } frsc_cfg_t;

endpackage

@@ rtl/frsc_cfg_regs.sv @@
module frsc_cfg_regs
    import frsc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [CFG_INDEX_BITS-1:0] wr_index,
    input  logic [CFG_DATA_BITS-1:0]  wr_data,
    output frsc_cfg_t                 cfg
);

    frsc_cfg_t cfg_reg;
    frsc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_MOMENTARY_MODE:  cfg_next.momentary_mode  = wr_data[0];
                CFG_EXT_PATCH_LIMIT: cfg_next.ext_patch_limit = wr_data[5:0];
                CFG_DEBOUNCE_MS:     cfg_next.debounce_ms     = wr_data[7:0];
                CFG_EDGE_HOLDOFF_US: cfg_next.edge_holdoff_us = wr_data[15:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.momentary_mode  <= RST_MOMENTARY_MODE;
            cfg_reg.ext_patch_limit <= RST_EXT_PATCH_LIMIT;
            cfg_reg.debounce_ms     <= RST_DEBOUNCE_MS;
            cfg_reg.edge_holdoff_us <= RST_EDGE_HOLDOFF_US;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/frsc_core.sv @@
module frsc_core
    import frsc_pkg::*;
#(
    parameter int DATA_BITS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  frsc_in_t  item,
    input  frsc_cfg_t cfg,
    output frsc_out_t result
);

    logic [DATA_BITS-1:0] out_word_reg;
    logic [DATA_BITS-1:0] out_word_next;
    logic [DATA_BITS-1:0] last_latched_reg;
    logic [DATA_BITS-1:0] last_latched_next;
    logic [DATA_BITS-1:0] saved_word_reg;
    logic [DATA_BITS-1:0] saved_word_next;
    logic                 edge_pending_reg;
    logic                 edge_pending_next;
    logic [31:0]          last_edge_us_reg;
    logic [31:0]          last_edge_us_next;
    logic [31:0]          last_action_ms_reg;
    logic [31:0]          last_action_ms_next;
    logic                 access_active_reg;
    logic                 access_active_next;

    logic [31:0] us_elapsed;
    logic [31:0] ms_elapsed;
    logic        holdoff_ok;
    logic        debounce_ok;
    logic        custom;
    logic        do_latch;
    logic        accepted;

    assign us_elapsed  = item.now_us - last_edge_us_reg;
    assign ms_elapsed  = item.now_ms - last_action_ms_reg;
    assign holdoff_ok  = us_elapsed >= {16'd0, cfg.edge_holdoff_us};
    assign debounce_ok = ms_elapsed >= {24'd0, cfg.debounce_ms};
    assign custom      = {1'b0, item.program_req} < cfg.ext_patch_limit;

    always_comb
    begin
        out_word_next       = out_word_reg;
        last_latched_next   = last_latched_reg;
        saved_word_next     = saved_word_reg;
        edge_pending_next   = edge_pending_reg;
        last_edge_us_next   = last_edge_us_reg;
        last_action_ms_next = last_action_ms_reg;
        access_active_next  = access_active_reg;
        do_latch            = 1'b0;
        accepted            = 1'b0;

        unique case (item.operation)
            OP_EDGE:
            begin
                if (holdoff_ok)
                begin
                    last_edge_us_next = item.now_us;
                    edge_pending_next = 1'b1;
                end
            end
            OP_REFRESH:
            begin
                if (!access_active_reg)
                begin
                    // A pending footswitch edge is taken once the debounce time is over.
                    if (edge_pending_reg && debounce_ok)
                    begin
                        edge_pending_next   = 1'b0;
                        last_action_ms_next = item.now_ms;
                        if (cfg.momentary_mode)
                        begin
                            out_word_next[BIT_RELAY] = !item.pin_level;
                        end
                        else if (!item.pin_level)
                        begin
                            out_word_next[BIT_RELAY] = !out_word_reg[BIT_RELAY];
                        end
                    end
                    out_word_next[BIT_T0] = custom;
                    for (int k = 0; k < BANK_COUNT; k++)
                    begin
                        out_word_next[BIT_S0 + k]  = item.program_req[k];
                        out_word_next[BIT_EN0 + k] =
                            !(custom && (item.program_req[4:3] == 2'(k)));
                    end
                end
                do_latch = 1'b1;
            end
            OP_BEGIN:
            begin
                if ((item.bank_index != 2'd0) && !access_active_reg)
                begin
                    saved_word_next          = out_word_reg;
                    edge_pending_next        = 1'b0;
                    last_edge_us_next        = item.now_us;
                    last_action_ms_next      = item.now_ms;
                    access_active_next       = 1'b1;
                    out_word_next[BIT_RELAY] = 1'b0;
                    out_word_next[BIT_T0]    = 1'b0;
                    // Only the selected bank's active-low enable is pulled low.
                    for (int k = 0; k < BANK_COUNT; k++)
                    begin
                        out_word_next[BIT_EN0 + k] = item.bank_index != 2'(k + 1);
                    end
                    do_latch = 1'b1;
                    accepted = 1'b1;
                end
            end
            OP_END:
            begin
                if (access_active_reg)
                begin
                    out_word_next       = saved_word_reg;
                    edge_pending_next   = 1'b0;
                    last_edge_us_next   = item.now_us;
                    last_action_ms_next = item.now_ms;
                    access_active_next  = 1'b0;
                    do_latch            = 1'b1;
                end
            end
            default:
            begin
                do_latch = 1'b0;
            end
        endcase

        if (do_latch && (out_word_next != last_latched_reg))
        begin
            last_latched_next = out_word_next;
        end
    end

    assign result.pattern     = out_word_next[PATTERN_BITS-1:0];
    assign result.latched     = do_latch && (out_word_next != last_latched_reg);
    assign result.accepted    = accepted;
    assign result.eeprom_mode = access_active_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_word_reg       <= '0;
            last_latched_reg   <= '0;
            edge_pending_reg   <= 1'b0;
            last_edge_us_reg   <= '0;
            last_action_ms_reg <= '0;
            access_active_reg  <= 1'b0;
        end
        else if (fire)
        begin
            out_word_reg       <= out_word_next;
            last_latched_reg   <= last_latched_next;
            edge_pending_reg   <= edge_pending_next;
            last_edge_us_reg   <= last_edge_us_next;
            last_action_ms_reg <= last_action_ms_next;
            access_active_reg  <= access_active_next;
        end
    end

    // The saved word has no reset; it is only read after a begin has written it.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            saved_word_reg <= saved_word_next;
        end
    end

`ifndef SYNTHESIS
    a_latch_tracks_word: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.latched |=> last_latched_reg == out_word_reg)
        else $error("latched word register does not follow the shifted-out word");

    a_access_starts_on_begin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(access_active_reg) |-> $past(fire && (item.operation == OP_BEGIN)))
        else $error("access became active without a begin");

    a_word_frozen_in_access: assert property (@(posedge clk) disable iff (!rst_n)
        access_active_reg && $past(access_active_reg) |-> $stable(out_word_reg))
        else $error("output word changed during an active access");

    a_accept_sets_mode: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.accepted |-> result.eeprom_mode && !access_active_reg)
        else $error("begin accepted without entering access mode");
`endif

endmodule

@@ rtl/footswitch_relay_shift_out_control_core.sv @@
// Channel   Direction  Handshake                 Payload
// in        input      in_valid / in_stall       in_data (frsc_in_t)
// out       output     out_valid / out_stall     out_data (frsc_out_t)
// cfg       input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item is taken per clock cycle while the input is not stalled; a result
// passes through the input register and then the result register before it is
// transferred out. The rate is set by the single combinational step between
// those two registers.
// Reset is asynchronous and active low; it clears all control state and returns
// the configuration to its reset values.
// A stall on the output holds the result register, and the input stalls only
// while the input register is occupied and a full result register is stalled.
module footswitch_relay_shift_out_control_core
    import frsc_pkg::*;
#(
    parameter int DATA_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  frsc_in_t                  in_data,

    output logic                      out_valid,
    input  logic                      out_stall,
    output frsc_out_t                 out_data,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    frsc_cfg_t cfg;
    frsc_out_t step_result;

    // Input register: holds one item until the step can pass it on.
    logic     in_full_reg;
    logic     in_full_next;
    frsc_in_t in_item_reg;

    // Result register: holds one result until the receiver takes it.
    logic      out_valid_reg;
    logic      out_valid_next;
    frsc_out_t out_data_reg;

    logic in_transfer;
    logic out_free;
    logic fire;

    // The configuration port never pushes back.
    assign cfg_ready = 1'b1;

    frsc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The result register can take a new result when it is empty or being read.
    assign out_free    = !out_valid_reg || !out_stall;
    assign fire        = in_full_reg && out_free;
    assign in_stall    = in_full_reg && !out_free;
    assign in_transfer = in_valid && !in_stall;

    assign in_full_next   = in_transfer || (in_full_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    frsc_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            in_item_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
